>>> sv/jsr_pkg.sv
// ----------------------------------------------------------------------------
// jsr_pkg: shared types and constants for the jet recombiner
// Sequencer state encoding, multiply step encoding, fixed field widths.
// ----------------------------------------------------------------------------
package jsr_pkg;

  // Fixed field widths
  localparam int PART_E_BITS  = 20;  // particle energy
  localparam int JET_E_BITS   = 24;  // accumulated jet energy
  localparam int PT_GUARD     = 4;   // extra bits on the jet pt accumulator
  localparam int ETA_INT_BITS = 4;   // integer bits of Q4.x pseudorapidity

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_ETA,
    ST_DIV_PHI,
    ST_DONE
  } seq_state_t;

  // Multiply schedule: one product per cycle, then a drain step
  typedef enum logic [2:0] {
    MS_ETA_JET,
    MS_ETA_PAR,
    MS_PHI_JET,
    MS_PHI_PAR,
    MS_FLUSH
  } mul_step_t;

endpackage

>>> sv/jsr_div.sv
// ----------------------------------------------------------------------------
// jsr_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncation toward zero.
// The quotient magnitude must fit in QUO_W bits (caller guarantees it).
// ----------------------------------------------------------------------------
module jsr_div #(
  parameter int DEN_W = 21,
  parameter int QUO_W = 17
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DEN_W+QUO_W-1:0] num,
  input  logic        [DEN_W-1:0]  den,
  output logic                     busy,
  output logic                     done,
  output logic signed [QUO_W:0]    quo
);

  localparam int NUM_W = DEN_W + QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] work;     // low dividend bits out at top, quotient bits in at bottom
  logic [DEN_W-1:0] den_r;
  logic             neg;
  logic [CNT_W-1:0] cnt;

  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [QUO_W:0]   q_ext;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem, work[QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign q_ext = {1'b0, work};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      // upper dividend bits are already below den, skip those steps
      rem   <= mag[NUM_W-1:QUO_W];
      work  <= mag[QUO_W-1:0];
      den_r <= den;
      neg   <= num[NUM_W-1];
    end else if (busy) begin
      if (cnt != '0) begin
        rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        work <= {work[QUO_W-2:0], ge};
      end else begin
        quo <= neg ? -$signed(q_ext) : $signed(q_ext);
      end
    end
  end

endmodule

>>> sv/jet_snowmass_recombiner_core.sv
// ----------------------------------------------------------------------------
// jet_snowmass_recombiner_core: Snowmass pt-weighted jet recombination
// Loads or merges one particle per transfer into the held jet: saturating
// energy and pt sums, pt-weighted eta and phi averages on the short arc.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  -----------------------------------------
//  in       in_valid / in_ready    start_jet, particle_energy, particle_pt,
//                                  particle_eta, particle_phi
//  out      out_valid / out_ready  jet_energy_out, jet_pt_out, jet_eta_out,
//                                  jet_phi_out, sum_saturated, zero_pt
//
//  A start transfer or a zero pt sum goes straight to the final step; a merge
//  first runs one shared multiplier (4 products + drain), then one shared
//  divider twice at one quotient bit per cycle for QW quotient bits,
//  QW = max(eta width, angle width + 1). The final step loads the output
//  register, and the next transfer is taken in the cycle after that load.
//  Reset clears the jet to zero energy, pt, eta and phi; no clearing pass.
//  in_ready is high only while the sequencer is idle. A finished result sits
//  in the output register; the next particle is taken meanwhile and waits in
//  the final step only if that register is still full.
//
module jet_snowmass_recombiner_core #(
  parameter int PT_BITS       = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int ETA_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // particle in
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  start_jet,
  input  logic [jsr_pkg::PART_E_BITS-1:0]       particle_energy,
  input  logic [PT_BITS-1:0]                    particle_pt,
  input  logic signed [jsr_pkg::ETA_INT_BITS+ETA_FRAC_BITS-1:0] particle_eta,
  input  logic signed [ANGLE_BITS-1:0]          particle_phi,
  // jet out
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [jsr_pkg::JET_E_BITS-1:0]        jet_energy_out,
  output logic [PT_BITS+jsr_pkg::PT_GUARD-1:0]  jet_pt_out,
  output logic signed [jsr_pkg::ETA_INT_BITS+ETA_FRAC_BITS-1:0] jet_eta_out,
  output logic signed [ANGLE_BITS-1:0]          jet_phi_out,
  output logic                                  sum_saturated,
  output logic                                  zero_pt
);

  import jsr_pkg::*;

  localparam int ETA_BITS = ETA_INT_BITS + ETA_FRAC_BITS;
  localparam int JPT_BITS = PT_BITS + PT_GUARD;
  // quotient magnitude bound: eta mean <= 2^(ETA_BITS-1), unwrapped phi < 2^ANGLE_BITS
  localparam int QW       = (ETA_BITS > ANGLE_BITS + 1) ? ETA_BITS : ANGLE_BITS + 1;
  localparam int DEN_W    = JPT_BITS + 1;   // exact, unclipped pt sum
  localparam int NUM_W    = DEN_W + QW;     // weighted sum
  localparam int MB_W     = QW + 1;         // signed angle operand of the multiplier

  localparam logic signed [MB_W-1:0] HALF = MB_W'(1) << (ANGLE_BITS - 1);
  localparam logic signed [MB_W-1:0] TURN = MB_W'(1) << ANGLE_BITS;

  seq_state_t state, state_next;
  mul_step_t  mstep;

  // jet state
  logic [JET_E_BITS-1:0]        jet_energy;
  logic [JPT_BITS-1:0]          jet_pt;
  logic signed [ETA_BITS-1:0]   jet_eta;
  logic signed [ANGLE_BITS-1:0] jet_phi;

  // per-particle working registers
  logic [JPT_BITS-1:0]          w_jet;    // jet pt before this merge
  logic [PT_BITS-1:0]           p_pt;
  logic signed [ETA_BITS-1:0]   p_eta;
  logic signed [ANGLE_BITS-1:0] p_phi;
  logic signed [MB_W-1:0]       jphi;     // jet phi moved onto the short arc
  logic [DEN_W-1:0]             den;
  logic signed [NUM_W-1:0]      prod;
  logic signed [NUM_W-1:0]      eta_num;
  logic signed [NUM_W-1:0]      phi_num;
  logic                         sat_flag;
  logic                         zero_flag;

  // control strobes
  logic in_xfer;
  logic out_load;
  logic div_start;
  logic div_busy;
  logic div_done;
  logic signed [QW:0] div_quo;

  // entry arithmetic
  logic [JET_E_BITS:0]     e_sum;
  logic [DEN_W-1:0]        pt_exact;
  logic                    zero_sum;
  logic signed [MB_W-1:0]  dphi;
  logic signed [MB_W-1:0]  jphi_adj;

  // shared multiplier operands
  logic [JPT_BITS-1:0]     mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [NUM_W:0]   mul_full;

  assign e_sum    = {1'b0, jet_energy} + (JET_E_BITS + 1)'(particle_energy);
  assign pt_exact = {1'b0, jet_pt} + DEN_W'(particle_pt);
  assign zero_sum = (pt_exact == '0);
  assign dphi     = MB_W'(jet_phi) - MB_W'(particle_phi);

  // difference of exactly half a turn leaves the jet phi alone
  always_comb begin
    jphi_adj = MB_W'(jet_phi);
    if (dphi < -HALF) begin
      jphi_adj = MB_W'(jet_phi) + TURN;
    end else if (dphi > HALF) begin
      jphi_adj = MB_W'(jet_phi) - TURN;
    end
  end

  always_comb begin
    case (mstep)
      MS_ETA_JET: begin
        mul_a = w_jet;
        mul_b = MB_W'(jet_eta);
      end
      MS_ETA_PAR: begin
        mul_a = JPT_BITS'(p_pt);
        mul_b = MB_W'(p_eta);
      end
      MS_PHI_JET: begin
        mul_a = w_jet;
        mul_b = jphi;
      end
      MS_PHI_PAR: begin
        mul_a = JPT_BITS'(p_pt);
        mul_b = MB_W'(p_phi);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = $signed({1'b0, mul_a}) * mul_b;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (start_jet || zero_sum) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mstep == MS_FLUSH) begin
          div_start  = 1'b1;
          state_next = ST_DIV_ETA;
        end
      end
      ST_DIV_ETA: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_PHI;
        end
      end
      ST_DIV_PHI: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_xfer = in_valid && in_ready;

  // jet state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      jet_energy <= '0;
      jet_pt     <= '0;
      jet_eta    <= '0;
      jet_phi    <= '0;
    end else begin
      if (in_xfer) begin
        if (start_jet) begin
          jet_energy <= JET_E_BITS'(particle_energy);
          jet_pt     <= JPT_BITS'(particle_pt);
          jet_eta    <= particle_eta;
          jet_phi    <= particle_phi;
        end else begin
          jet_energy <= e_sum[JET_E_BITS] ? '1 : e_sum[JET_E_BITS-1:0];
          jet_pt     <= pt_exact[JPT_BITS] ? '1 : pt_exact[JPT_BITS-1:0];
        end
      end
      if (div_done && state == ST_DIV_ETA) begin
        jet_eta <= div_quo[ETA_BITS-1:0];
      end
      // phi quotient reduced to one turn by dropping the upper bits
      if (div_done && state == ST_DIV_PHI) begin
        jet_phi <= div_quo[ANGLE_BITS-1:0];
      end
    end
  end

  // multiply schedule counter
  always_ff @(posedge clk) begin
    if (rst) begin
      mstep <= MS_ETA_JET;
    end else if (in_xfer) begin
      mstep <= MS_ETA_JET;
    end else if (state == ST_MUL && mstep != MS_FLUSH) begin
      mstep <= mul_step_t'(mstep + 3'd1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      w_jet     <= jet_pt;
      p_pt      <= particle_pt;
      p_eta     <= particle_eta;
      p_phi     <= particle_phi;
      jphi      <= jphi_adj;
      den       <= pt_exact;
      sat_flag  <= !start_jet && (e_sum[JET_E_BITS] || pt_exact[JPT_BITS]);
      zero_flag <= start_jet ? (particle_pt == '0) : zero_sum;
    end
    if (state == ST_MUL) begin
      // product registered, accumulated in the following step
      prod <= mul_full[NUM_W-1:0];
      case (mstep)
        MS_ETA_PAR: eta_num <= prod;
        MS_PHI_JET: eta_num <= eta_num + prod;
        MS_PHI_PAR: phi_num <= prod;
        MS_FLUSH:   phi_num <= phi_num + prod;
        default:    ;
      endcase
    end
  end

  // eta sum is complete when the first divide starts, phi sum by the second
  jsr_div #(
    .DEN_W (DEN_W),
    .QUO_W (QW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ((state == ST_MUL) ? eta_num : phi_num),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      jet_energy_out <= jet_energy;
      jet_pt_out     <= jet_pt;
      jet_eta_out    <= jet_eta;
      jet_phi_out    <= jet_phi;
      sum_saturated  <= sat_flag;
      zero_pt        <= zero_flag;
    end
  end

`ifndef ASSERT_OFF
  // divider only runs while the sequencer waits on it
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIV_ETA || state == ST_DIV_PHI))
    else $error("divider busy outside a divide step");

  // a finished division lands only in a divide step
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_ETA || state == ST_DIV_PHI))
    else $error("divider done outside a divide step");

  // a particle transfer always leaves the idle state
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("ready again right after a particle transfer");

  // output register never overwritten while full and stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output overwritten while stalled");
`endif

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for jet_snowmass_recombiner_core
// Drives particles over the valid/ready input channel, predicts every jet
// result with a behavioral recombiner, and checks each output transfer
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

  import jsr_pkg::*;

  localparam int PT_BITS       = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int ETA_FRAC_BITS = 12;
  localparam int ETA_BITS      = ETA_INT_BITS + ETA_FRAC_BITS;
  localparam int JET_PT_BITS   = PT_BITS + PT_GUARD;

  localparam logic [PART_E_BITS-1:0] E_PART_MAX = '1;
  localparam logic [PT_BITS-1:0]     PT_MAX     = '1;
  localparam longint JET_E_MAX  = (longint'(1) <<< JET_E_BITS) - 1;
  localparam longint JET_PT_MAX = (longint'(1) <<< JET_PT_BITS) - 1;
  localparam longint HALF_TURN  = longint'(1) <<< (ANGLE_BITS - 1);
  localparam longint FULL_TURN  = longint'(1) <<< ANGLE_BITS;

  // drain allowance after the last transfer, a bit over one merge
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [JET_E_BITS-1:0]      energy;
    logic [JET_PT_BITS-1:0]     pt;
    logic signed [ETA_BITS-1:0] eta;
    logic signed [ANGLE_BITS-1:0] phi;
    logic                       sat;
    logic                       zero;
  } jet_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid        = 1'b0;
  logic                          in_ready;
  logic                          start_jet       = 1'b0;
  logic [PART_E_BITS-1:0]        particle_energy = '0;
  logic [PT_BITS-1:0]            particle_pt     = '0;
  logic signed [ETA_BITS-1:0]    particle_eta    = '0;
  logic signed [ANGLE_BITS-1:0]  particle_phi    = '0;

  logic                          out_valid;
  logic                          out_ready       = 1'b0;
  logic [JET_E_BITS-1:0]         jet_energy_out;
  logic [JET_PT_BITS-1:0]        jet_pt_out;
  logic signed [ETA_BITS-1:0]    jet_eta_out;
  logic signed [ANGLE_BITS-1:0]  jet_phi_out;
  logic                          sum_saturated;
  logic                          zero_pt;

  jet_snowmass_recombiner_core #(
    .PT_BITS       (PT_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .ETA_FRAC_BITS (ETA_FRAC_BITS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .start_jet       (start_jet),
    .particle_energy (particle_energy),
    .particle_pt     (particle_pt),
    .particle_eta    (particle_eta),
    .particle_phi    (particle_phi),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .jet_energy_out  (jet_energy_out),
    .jet_pt_out      (jet_pt_out),
    .jet_eta_out     (jet_eta_out),
    .jet_phi_out     (jet_phi_out),
    .sum_saturated   (sum_saturated),
    .zero_pt         (zero_pt)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hang guard, roughly ten times the slowest legal run
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: private copy of the held jet
  // --------------------------------------------------------------------------
  logic [JET_E_BITS-1:0]        jet_energy_q = '0;
  logic [JET_PT_BITS-1:0]       jet_pt_q     = '0;
  logic signed [ETA_BITS-1:0]   jet_eta_q    = '0;
  logic signed [ANGLE_BITS-1:0] jet_phi_q    = '0;

  jet_result_t pending_jets[$];
  jet_result_t want;
  int          error_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Load or merge one particle, return the jet as it stands afterwards.
  function automatic jet_result_t recombine_jet(
    input logic                         start,
    input logic [PART_E_BITS-1:0]       pe,
    input logic [PT_BITS-1:0]           ppt,
    input logic signed [ETA_BITS-1:0]   peta,
    input logic signed [ANGLE_BITS-1:0] pphi
  );
    jet_result_t r;
    longint pt_sum, e_sum, jphi, dphi, eta_num, phi_num, q;
    r.sat  = 1'b0;
    r.zero = 1'b0;
    if (start) begin
      jet_energy_q = JET_E_BITS'(pe);
      jet_pt_q     = JET_PT_BITS'(ppt);
      jet_eta_q    = peta;
      jet_phi_q    = pphi;
      r.zero       = (ppt == '0);
    end else begin
      pt_sum = longint'(jet_pt_q) + longint'(ppt);
      e_sum  = longint'(jet_energy_q) + longint'(pe);
      if (e_sum > JET_E_MAX) begin
        e_sum = JET_E_MAX;
        r.sat = 1'b1;
      end
      jet_energy_q = e_sum[JET_E_BITS-1:0];
      if (pt_sum == 0) begin
        // nothing to weight with: angles stay put
        r.zero = 1'b1;
      end else begin
        // unwrap the jet phi onto the short arc; exactly half a turn stays
        jphi = longint'(jet_phi_q);
        dphi = jphi - longint'(pphi);
        if (dphi < -HALF_TURN)
          jphi = jphi + FULL_TURN;
        else if (dphi > HALF_TURN)
          jphi = jphi - FULL_TURN;
        // weights use the held (possibly clipped) pt, divisor the exact sum
        eta_num   = longint'(jet_pt_q) * longint'(jet_eta_q) +
                    longint'(ppt) * longint'(peta);
        phi_num   = longint'(jet_pt_q) * jphi + longint'(ppt) * longint'(pphi);
        q         = eta_num / pt_sum;
        jet_eta_q = q[ETA_BITS-1:0];
        q         = phi_num / pt_sum;
        jet_phi_q = q[ANGLE_BITS-1:0];
      end
      if (pt_sum > JET_PT_MAX) begin
        pt_sum = JET_PT_MAX;
        r.sat  = 1'b1;
      end
      jet_pt_q = pt_sum[JET_PT_BITS-1:0];
    end
    r.energy = jet_energy_q;
    r.pt     = jet_pt_q;
    r.eta    = jet_eta_q;
    r.phi    = jet_phi_q;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random out_ready, compare every output transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_jets.size() == 0) begin
        flag_error("output transfer with no pending jet");
      end else begin
        want = pending_jets.pop_front();
        if (jet_energy_out !== want.energy)
          flag_error($sformatf("energy %0d, want %0d", jet_energy_out, want.energy));
        if (jet_pt_out !== want.pt)
          flag_error($sformatf("pt %0d, want %0d", jet_pt_out, want.pt));
        if (jet_eta_out !== want.eta)
          flag_error($sformatf("eta %0d, want %0d", jet_eta_out, want.eta));
        if (jet_phi_out !== want.phi)
          flag_error($sformatf("phi %0d, want %0d", jet_phi_out, want.phi));
        if (sum_saturated !== want.sat)
          flag_error($sformatf("sum_saturated %0b, want %0b", sum_saturated, want.sat));
        if (zero_pt !== want.zero)
          flag_error($sformatf("zero_pt %0b, want %0b", zero_pt, want.zero));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Input side: one particle transfer, prediction queued at acceptance.
  // Called right after a rising edge; valid stays high between back-to-back
  // particles, so only one assignment to in_valid lands per edge.
  // --------------------------------------------------------------------------
  task automatic send_particle(
    input logic                         start,
    input logic [PART_E_BITS-1:0]       pe,
    input logic [PT_BITS-1:0]           ppt,
    input logic signed [ETA_BITS-1:0]   peta,
    input logic signed [ANGLE_BITS-1:0] pphi
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    start_jet       <= start;
    particle_energy <= pe;
    particle_pt     <= ppt;
    particle_eta    <= peta;
    particle_phi    <= pphi;
    do @(posedge clk); while (!in_ready);
    pending_jets.push_back(recombine_jet(start, pe, ppt, peta, pphi));
  endtask

  // --------------------------------------------------------------------------
  // Random field values, weighted toward edges
  // --------------------------------------------------------------------------
  function automatic logic [PART_E_BITS-1:0] rand_energy();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return E_PART_MAX;
      2:       return PART_E_BITS'($urandom_range(0, 255));
      default: return PART_E_BITS'($urandom);
    endcase
  endfunction

  // heavy jets lean on large pt so the 20-bit sum clips
  function automatic logic [PT_BITS-1:0] rand_pt(input bit heavy);
    if (heavy && $urandom_range(0, 1) == 0)
      return PT_MAX;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PT_MAX;
      2:       return PT_BITS'($urandom_range(1, 15));
      default: return PT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'($urandom_range(0, 31)) - 16'sd16;
      3:       return 16'sh8000 + 16'($urandom_range(0, 31)) - 16'sd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Start with zero pt at the negative extremes, then merges: first a zero pt
  // sum (angles kept, energy summed), a weighted particle, then a weight-free one.
  task automatic test_zero_pt();
    send_particle(1'b1, '0, '0, 16'sh8000, 16'sh8000);
    send_particle(1'b0, E_PART_MAX, '0, 16'sh7FFF, 16'sh7FFF);
    send_particle(1'b0, 20'd5, 16'd300, 16'sh1000, 16'sh4000);
    send_particle(1'b0, 20'd7, '0, 16'sh8000, 16'sh8000);
  endtask

  // Full-scale particles with phi flipping across the wrap point, until both
  // sums clip; the averages keep dividing by the exact sum.
  task automatic test_saturation_and_wrap();
    int k;
    send_particle(1'b1, E_PART_MAX, PT_MAX, 16'sh7FFF, 16'sh7FFF);
    for (k = 0; k < 16; k++)
      send_particle(1'b0, E_PART_MAX, PT_MAX, k[0] ? 16'sh7FFF : 16'sh8000,
                    k[0] ? 16'sh7FFF : 16'sh8000);
  endtask

  // Differences of exactly plus and minus half a turn leave the jet phi alone.
  task automatic test_half_turn();
    send_particle(1'b1, 20'd100, 16'd100, 16'sh0000, 16'sh0000);
    send_particle(1'b0, 20'd100, 16'd100, -16'sh0800, 16'sh8000);
    send_particle(1'b1, 20'd10, 16'd10, 16'sh0400, -16'sh4000);
    send_particle(1'b0, 20'd10, 16'd10, -16'sh0400, 16'sh4000);
  endtask

  // Jets of random length with random content; a few stray start flags in
  // the middle of a jet act as noise.
  task automatic test_random_jets(input int n_items);
    int  sent, n_merge, k;
    bit  heavy;
    sent = 0;
    while (sent < n_items) begin
      heavy   = ($urandom_range(0, 3) == 0);
      n_merge = heavy ? $urandom_range(16, 40) : $urandom_range(0, 8);
      send_particle(1'b1, rand_energy(), rand_pt(heavy), rand_angle(), rand_angle());
      sent++;
      for (k = 0; k < n_merge; k++) begin
        send_particle($urandom_range(0, 19) == 0, rand_energy(), rand_pt(heavy),
                      rand_angle(), rand_angle());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed tests, random in three idling phases, drain
  // --------------------------------------------------------------------------
  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 83;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_zero_pt();
    test_saturation_and_wrap();
    test_half_turn();
    test_random_jets(400);

    send_idle_pct = 83;
    recv_idle_pct = 32;
    test_random_jets(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_jets(400);

    in_valid <= 1'b0;
    while (pending_jets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
